// ===== design/r6pq_pkg.sv =====
// Shared constants, types and GF(2^8) helpers for the RAID6 P/Q stripe checker.
package r6pq_pkg;

	localparam int MAX_DISK_COUNT = 64;
	localparam int DATA_COLS      = MAX_DISK_COUNT - 2;
	localparam int COL_W          = 6;
	localparam int BYTE_W         = 8;
	localparam int COEF_DEPTH     = 2 ** COL_W;

	localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1d;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_PARITY   = 2'd1,
		STATUS_DEGRADED = 2'd2
	} stripe_status_t;

	typedef logic [COEF_DEPTH-1:0][BYTE_W-1:0] coef_table_t;

	// multiply by x, reduce by x^8+x^4+x^3+x^2+1
	function automatic byte_t gf_double(input byte_t v);
		byte_t r;
		r = {v[BYTE_W-2:0], 1'b0};
		if (v[BYTE_W-1]) begin
			r = r ^ GF_POLY_LOW;
		end
		return r;
	endfunction

	// shift-and-add product, eight narrow steps
	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t sh;
		acc = '0;
		sh  = a;
		for (int i = 0; i < BYTE_W; i++) begin
			if (b[i]) begin
				acc = acc ^ sh;
			end
			sh = gf_double(sh);
		end
		return acc;
	endfunction

	// 2^col for every column code, built at elaboration
	function automatic coef_table_t gf_pow2_table();
		coef_table_t t;
		byte_t c;
		c = 8'h01;
		for (int i = 0; i < COEF_DEPTH; i++) begin
			t[i] = c;
			c = gf_double(c);
		end
		return t;
	endfunction

	localparam coef_table_t GF_POW2 = gf_pow2_table();

endpackage

// ===== design/r6pq_q_term.sv =====
// Q syndrome term: GF(2^8) product of the column coefficient 2^col and the data byte.
module r6pq_q_term (
	input  logic [r6pq_pkg::COL_W-1:0] col,
	input  r6pq_pkg::byte_t            data_byte,
	output r6pq_pkg::byte_t            term
);

	r6pq_pkg::byte_t coef;

	assign coef = r6pq_pkg::GF_POW2[col];
	assign term = r6pq_pkg::gf_mul(coef, data_byte);

endmodule

// ===== design/raid6_pq_stripe_checker.sv =====
// RAID6 P/Q stripe checker top level: input register, accumulators, result register.
// A check item passes the input register and then the result register.
// Throughput: one item per cycle while in_stall is low; data items produce no result.
// The accumulator update is one XOR plus a GF multiply by the table value 2^col per cycle.
// Reset (arst_n low, asynchronous): both stages empty, accumulators and stripe
// flags cleared, so the first stripe starts from zero.
module raid6_pq_stripe_checker (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [r6pq_pkg::COL_W-1:0] col,
	input  logic [7:0]                 data_byte,
	input  logic                       col_missing,
	input  logic [7:0]                 p_stored,
	input  logic [7:0]                 q_stored,
	input  logic                       p_missing,
	input  logic                       q_missing,
	input  logic                       last_in_stripe,

	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 p_calc,
	output logic [7:0]                 q_calc,
	output logic                       p_byte_bad,
	output logic                       q_byte_bad,
	output logic                       stripe_done,
	output logic [1:0]                 stripe_status,
	output logic                       p_mismatch_any,
	output logic                       q_mismatch_any
);

	// ---------------- input register (stage 1) ----------------
	logic                       valid_s1;
	logic                       cmd_s1;
	logic [r6pq_pkg::COL_W-1:0] col_s1;
	r6pq_pkg::byte_t            data_s1;
	logic                       col_missing_s1;
	r6pq_pkg::byte_t            p_stored_s1;
	r6pq_pkg::byte_t            q_stored_s1;
	logic                       p_missing_s1;
	logic                       q_missing_s1;
	logic                       last_s1;

	// ---------------- per-stripe state ----------------
	r6pq_pkg::byte_t p_accum_q;
	r6pq_pkg::byte_t q_accum_q;
	logic            degraded_q;
	logic            p_err_q;
	logic            q_err_q;

	// ---------------- result register ----------------
	logic                     out_valid_q;
	r6pq_pkg::byte_t          p_calc_q;
	r6pq_pkg::byte_t          q_calc_q;
	logic                     p_bad_q;
	logic                     q_bad_q;
	logic                     done_q;
	r6pq_pkg::stripe_status_t status_q;
	logic                     p_any_q;
	logic                     q_any_q;

	// ---------------- stage 1 logic ----------------
	logic                     in_xfer;
	logic                     s1_go;
	logic                     data_go;
	logic                     check_go;
	logic                     col_ok;
	r6pq_pkg::byte_t          data_eff;
	r6pq_pkg::byte_t          q_term;
	logic                     deg_next;
	logic                     p_bad;
	logic                     q_bad;
	logic                     p_err_next;
	logic                     q_err_next;
	r6pq_pkg::stripe_status_t status_next;

	// A data item never needs the result register, so it always moves on.
	// A check item moves when the result register is free or being emptied.
	assign s1_go    = valid_s1 & (~cmd_s1 | ~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~s1_go;
	assign in_xfer  = in_valid & ~in_stall;
	assign data_go  = s1_go & ~cmd_s1;
	assign check_go = s1_go & cmd_s1;

	// Columns past the last data disk name nothing and are dropped.
	assign col_ok   = col_s1 < r6pq_pkg::COL_W'(r6pq_pkg::DATA_COLS);
	// An offline column contributes zero.
	assign data_eff = col_missing_s1 ? '0 : data_s1;

	r6pq_q_term u_q_term (
		.col       (col_s1),
		.data_byte (data_eff),
		.term      (q_term)
	);

	// Check: a missing parity disk degrades the stripe and hides its byte compare.
	assign deg_next   = degraded_q | p_missing_s1 | q_missing_s1;
	assign p_bad      = ~p_missing_s1 & (p_accum_q != p_stored_s1);
	assign q_bad      = ~q_missing_s1 & (q_accum_q != q_stored_s1);
	assign p_err_next = p_err_q | p_bad;
	assign q_err_next = q_err_q | q_bad;

	// On a stripe's last check item, degraded wins over parity error, which wins over ok; other check items report ok.
	always_comb begin
		status_next = r6pq_pkg::STATUS_OK;
		if (last_s1) begin
			if (deg_next) begin
				status_next = r6pq_pkg::STATUS_DEGRADED;
			end else if (p_err_next | q_err_next) begin
				status_next = r6pq_pkg::STATUS_PARITY;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1         <= cmd;
			col_s1         <= col;
			data_s1        <= data_byte;
			col_missing_s1 <= col_missing;
			p_stored_s1    <= p_stored;
			q_stored_s1    <= q_stored;
			p_missing_s1   <= p_missing;
			q_missing_s1   <= q_missing;
			last_s1        <= last_in_stripe;
		end
	end

	// accumulators and stripe flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_accum_q  <= '0;
			q_accum_q  <= '0;
			degraded_q <= 1'b0;
			p_err_q    <= 1'b0;
			q_err_q    <= 1'b0;
		end else if (data_go && col_ok) begin
			p_accum_q <= p_accum_q ^ data_eff;
			q_accum_q <= q_accum_q ^ q_term;
			if (col_missing_s1) begin
				degraded_q <= 1'b1;
			end
		end else if (check_go) begin
			p_accum_q <= '0;
			q_accum_q <= '0;
			if (last_s1) begin
				degraded_q <= 1'b0;
				p_err_q    <= 1'b0;
				q_err_q    <= 1'b0;
			end else begin
				degraded_q <= deg_next;
				p_err_q    <= p_err_next;
				q_err_q    <= q_err_next;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (check_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (check_go) begin
			p_calc_q <= p_accum_q;
			q_calc_q <= q_accum_q;
			p_bad_q  <= p_bad;
			q_bad_q  <= q_bad;
			done_q   <= last_s1;
			status_q <= status_next;
			p_any_q  <= p_err_next;
			q_any_q  <= q_err_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign p_calc         = p_calc_q;
	assign q_calc         = q_calc_q;
	assign p_byte_bad     = p_bad_q;
	assign q_byte_bad     = q_bad_q;
	assign stripe_done    = done_q;
	assign stripe_status  = status_q;
	assign p_mismatch_any = p_any_q;
	assign q_mismatch_any = q_any_q;

endmodule
